[rtl/normal_depth_shade_edge_darken_unit_defines.svh]
// Assertion macros, clocked on clk and disabled while arst_n is low.
`ifndef NORMAL_DEPTH_SHADE_EDGE_DARKEN_UNIT_DEFINES_SVH
`define NORMAL_DEPTH_SHADE_EDGE_DARKEN_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define NDSED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define NDSED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ndsed_pkg.sv]
package ndsed_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int SLOT_W     = $clog2(MAX_WIDTH);
	localparam int RAM_DEPTH  = 2 * MAX_WIDTH;
	localparam int ADDR_W     = $clog2(RAM_DEPTH);
	localparam int DIM_W      = 12;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 12;
	localparam int POS_W      = 11;
	localparam int DSUM_W     = 18;
	localparam int NSUM_W     = 36;
	localparam int SHADE_W    = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 34;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH      = 3'd0,
		CFG_HEIGHT     = 3'd1,
		CFG_DEPTH_THR  = 3'd2,
		CFG_DEPTH_DARK = 3'd3,
		CFG_NORM_THR   = 3'd4,
		CFG_NORM_DARK  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        [15:0] depth;
		logic signed [15:0] nz;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
	} geo_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic [DSUM_W-1:0] dsum;
		logic [NSUM_W-1:0] nsum;
	} edge_acc_t;

endpackage

[rtl/ndsed_in_if.sv]
interface ndsed_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic        [7:0]  in_red;
	logic        [7:0]  in_green;
	logic        [7:0]  in_blue;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic        [15:0] depth_index;

	modport source (output valid, cmd, in_red, in_green, in_blue, normal_x, normal_y,
		normal_z, depth_index, input ready);
	modport sink (input valid, cmd, in_red, in_green, in_blue, normal_x, normal_y,
		normal_z, depth_index, output ready);
endinterface

[rtl/ndsed_out_if.sv]
interface ndsed_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [10:0] out_column;
	logic [10:0] out_row;
	logic        frame_last;

	modport source (output valid, out_red, out_green, out_blue, out_column, out_row,
		frame_last, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_column, out_row,
		frame_last, output ready);
endinterface

[rtl/ndsed_ram.sv]
module ndsed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/ndsed_shade.sv]
module ndsed_shade (
	input  logic              clk,
	input  ndsed_pkg::rgb_t   color,
	input  ndsed_pkg::geo_t   geo,
	output ndsed_pkg::rgb_t   shaded
);
	localparam logic signed [13:0] COEF_X  = 14'sd5734;
	localparam logic signed [12:0] COEF_YZ = 13'sd1638;
	localparam logic signed [31:0] ONE_SQ  = 32'sd268435456;
	localparam logic signed [31:0] HALF_SQ = 32'sd134217728;
	localparam logic [ndsed_pkg::SHADE_W-1:0] S_ONE  = 15'd16384;
	localparam logic [ndsed_pkg::SHADE_W-1:0] S_HALF = 15'd8192;

	logic signed [29:0] px_s1;
	logic signed [29:0] pyz_s1;
	logic signed [31:0] sum_s2;
	logic [ndsed_pkg::SHADE_W-1:0] fac_s3;
	logic signed [16:0] yz;
	logic [22:0] pr, pg, pb;

	assign yz = {geo.ny[15], geo.ny} + {geo.nz[15], geo.nz};
	assign pr = color.r * fac_s3;
	assign pg = color.g * fac_s3;
	assign pb = color.b * fac_s3;

	always_ff @(posedge clk) begin
		px_s1  <= geo.nx * COEF_X;
		pyz_s1 <= 30'(yz * COEF_YZ);
		sum_s2 <= ONE_SQ - {{2{px_s1[29]}}, px_s1} - {{2{pyz_s1[29]}}, pyz_s1};
		if (sum_s2 <= HALF_SQ) begin
			fac_s3 <= S_HALF;
		end else if (sum_s2 >= ONE_SQ) begin
			fac_s3 <= S_ONE;
		end else begin
			fac_s3 <= sum_s2[28:14];
		end
		shaded.r <= pr[21:14];
		shaded.g <= pg[21:14];
		shaded.b <= pb[21:14];
	end
endmodule

[rtl/ndsed_edge_cell.sv]
module ndsed_edge_cell (
	input  logic                 clk,
	input  ndsed_pkg::geo_t      centre,
	input  ndsed_pkg::geo_t      neighbour,
	input  ndsed_pkg::edge_acc_t acc_in,
	output ndsed_pkg::edge_acc_t acc_out
);
	logic signed [16:0] dx_s1, dy_s1, dz_s1;
	logic        [15:0] dd_s1;
	logic signed [33:0] sqx, sqy, sqz;
	logic        [35:0] nsq_s2;
	logic        [15:0] dd_s2;

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;
	assign sqz = dz_s1 * dz_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= {neighbour.nx[15], neighbour.nx} - {centre.nx[15], centre.nx};
		dy_s1 <= {neighbour.ny[15], neighbour.ny} - {centre.ny[15], centre.ny};
		dz_s1 <= {neighbour.nz[15], neighbour.nz} - {centre.nz[15], centre.nz};
		dd_s1 <= (centre.depth > neighbour.depth) ? centre.depth - neighbour.depth
			: neighbour.depth - centre.depth;
		nsq_s2 <= {2'b0, sqx} + {2'b0, sqy} + {2'b0, sqz};
		dd_s2  <= dd_s1;
		acc_out.dsum <= acc_in.dsum + {2'b0, dd_s2};
		acc_out.nsum <= acc_in.nsum + nsq_s2;
	end
endmodule

[rtl/normal_depth_shade_edge_darken_unit.sv]
// channel  | dir | payload
// pixels   | in  | cmd, in_red/green/blue, normal_x/y/z, depth_index
// results  | out | out_red/green/blue, out_column, out_row, frame_last
// cfg      | in  | cfg_we, cfg_index, cfg_wdata (write only)
// One transaction at a time: it is accepted, read from the line stores through the
// single read port of each store, run through the chain of edge cells g_cell[0] to g_cell[3], then loaded.
// A drain item outside the drain row is taken in ST_IDLE without leaving it and yields nothing.
// After reset all 4096 entries of the line stores are zeroed, one entry a cycle, with ready low.
// A result waiting on results.ready holds the next item in ST_WAIT.
module normal_depth_shade_edge_darken_unit (
	input  logic        clk,
	input  logic        arst_n,
	ndsed_in_if.sink    pixels,
	ndsed_out_if.source results,
	input  logic        cfg_we,
	input  logic [ndsed_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ndsed_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	localparam int EVAL_CYCLES = 6;
	localparam int FETCH_LAST  = 4;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_WAIT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [ndsed_pkg::DIM_W-1:0] width_q, height_q;
	logic [17:0] dthr_q;
	logic [7:0]  ddark_q, ndark_q;
	logic [33:0] nthr_q;

	logic [ndsed_pkg::COL_W-1:0] cnt_col_q;
	logic [ndsed_pkg::ROW_W-1:0] cnt_row_q;
	logic [ndsed_pkg::COL_W-1:0] col_q;
	logic [ndsed_pkg::ROW_W-1:0] row_q;
	logic drain_q;
	ndsed_pkg::rgb_t rgb_in_q, colour_q, shaded;
	ndsed_pkg::geo_t geo_new_q;
	ndsed_pkg::geo_t win_q [4];

	logic [2:0] fcnt_q, ecnt_q;
	logic [ndsed_pkg::ADDR_W-1:0] clr_q;

	logic [ndsed_pkg::DIM_W-1:0] w, h;
	logic [12:0] r_norm, c_next, r_next;
	logic [ndsed_pkg::COL_W-1:0] c_norm;
	logic drain_n, ignore, accept;

	logic [ndsed_pkg::ROW_W-1:0] orow;
	logic emit, interior, dedge, nedge;
	logic [ndsed_pkg::ADDR_W-1:0] raddr, waddr;
	logic [63:0] geo_rdata, geo_wdata;
	logic [23:0] col_rdata, col_wdata;
	logic we;
	ndsed_pkg::edge_acc_t acc [5];
	ndsed_pkg::geo_t nb [4];
	ndsed_pkg::rgb_t dk1, dk2;
	logic out_valid_q, load;

	assign w = (width_q == '0) ? ndsed_pkg::DIM_W'(1)
		: (width_q > ndsed_pkg::DIM_W'(ndsed_pkg::MAX_WIDTH))
		? ndsed_pkg::DIM_W'(ndsed_pkg::MAX_WIDTH) : width_q;
	assign h = (height_q == '0) ? ndsed_pkg::DIM_W'(1)
		: (height_q > ndsed_pkg::DIM_W'(ndsed_pkg::MAX_HEIGHT))
		? ndsed_pkg::DIM_W'(ndsed_pkg::MAX_HEIGHT) : height_q;

	always_comb begin
		if ({1'b0, cnt_col_q} >= w) begin
			c_norm = '0;
			r_norm = {1'b0, cnt_row_q} + 13'd1;
		end else begin
			c_norm = cnt_col_q;
			r_norm = {1'b0, cnt_row_q};
		end
		if (r_norm > {1'b0, h}) begin
			r_norm = '0;
		end
		c_next = {2'b0, c_norm} + 13'd1;
		r_next = r_norm + 13'd1;
		if (c_next >= {1'b0, w}) begin
			c_next = '0;
			if (r_next > {1'b0, h}) begin
				r_next = '0;
			end
		end else begin
			r_next = r_norm;
		end
	end

	assign drain_n = r_norm >= {1'b0, h};
	assign ignore  = !drain_n && (pixels.cmd == ndsed_pkg::CMD_DRAIN);
	assign pixels.ready = (state_q == ST_IDLE);
	assign accept  = pixels.valid && pixels.ready;

	assign orow = row_q - ndsed_pkg::ROW_W'(1);
	assign emit = row_q != '0;
	assign interior = (col_q != '0) && ({2'b0, col_q} + 13'd1 < {1'b0, w})
		&& (orow != '0) && ({1'b0, orow} + 13'd1 < {1'b0, h});

	always_comb begin
		unique case (fcnt_q)
			3'd0:    raddr = {~row_q[0], col_q};
			3'd1:    raddr = {~row_q[0], col_q - ndsed_pkg::COL_W'(1)};
			3'd2:    raddr = {~row_q[0], col_q + ndsed_pkg::COL_W'(1)};
			default: raddr = {row_q[0], col_q};
		endcase
	end

	assign we = (state_q == ST_CLEAR)
		|| ((state_q == ST_FETCH) && (fcnt_q == 3'(FETCH_LAST)) && !drain_q);
	assign waddr = (state_q == ST_CLEAR) ? clr_q : {row_q[0], col_q};
	assign geo_wdata = (state_q == ST_CLEAR) ? '0 : geo_new_q;
	assign col_wdata = (state_q == ST_CLEAR) ? '0 : shaded;

	ndsed_ram #(.WIDTH(64), .DEPTH(ndsed_pkg::RAM_DEPTH)) u_geo_ram (
		.clk, .we, .waddr, .wdata(geo_wdata), .raddr, .rdata(geo_rdata));
	ndsed_ram #(.WIDTH(24), .DEPTH(ndsed_pkg::RAM_DEPTH)) u_col_ram (
		.clk, .we, .waddr, .wdata(col_wdata), .raddr, .rdata(col_rdata));

	ndsed_shade u_shade (.clk, .color(rgb_in_q), .geo(geo_new_q), .shaded);

	assign acc[0] = '0;
	assign nb[0] = win_q[1];
	assign nb[1] = win_q[2];
	assign nb[2] = win_q[3];
	assign nb[3] = geo_new_q;

	for (genvar k = 0; k < 4; k++) begin : g_cell
		ndsed_edge_cell u_cell (.clk, .centre(win_q[0]), .neighbour(nb[k]),
			.acc_in(acc[k]), .acc_out(acc[k+1]));
	end

	assign dedge = interior && (acc[4].dsum > dthr_q);
	assign nedge = interior && (acc[4].nsum > {2'b0, nthr_q});

	always_comb begin
		dk1 = colour_q;
		if (dedge) begin
			dk1.r = (dk1.r < ddark_q) ? '0 : dk1.r - ddark_q;
			dk1.g = (dk1.g < ddark_q) ? '0 : dk1.g - ddark_q;
			dk1.b = (dk1.b < ddark_q) ? '0 : dk1.b - ddark_q;
		end
		dk2 = dk1;
		if (nedge) begin
			dk2.r = (dk2.r < ndark_q) ? '0 : dk2.r - ndark_q;
			dk2.g = (dk2.g < ndark_q) ? '0 : dk2.g - ndark_q;
			dk2.b = (dk2.b < ndark_q) ? '0 : dk2.b - ndark_q;
		end
	end

	assign load = (state_q == ST_WAIT) && emit && (!out_valid_q || results.ready);
	assign results.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			dthr_q   <= 18'd15;
			ddark_q  <= 8'd64;
			nthr_q   <= 34'd268435456;
			ndark_q  <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ndsed_pkg::CFG_WIDTH:      width_q  <= cfg_wdata[11:0];
				ndsed_pkg::CFG_HEIGHT:     height_q <= cfg_wdata[11:0];
				ndsed_pkg::CFG_DEPTH_THR:  dthr_q   <= cfg_wdata[17:0];
				ndsed_pkg::CFG_DEPTH_DARK: ddark_q  <= cfg_wdata[7:0];
				ndsed_pkg::CFG_NORM_THR:   nthr_q   <= cfg_wdata[33:0];
				ndsed_pkg::CFG_NORM_DARK:  ndark_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			fcnt_q      <= '0;
			ecnt_q      <= '0;
			cnt_col_q   <= '0;
			cnt_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && ignore) begin
						// ignored drain still settles a wrapped position
						cnt_col_q <= c_norm;
						cnt_row_q <= r_norm[ndsed_pkg::ROW_W-1:0];
					end else if (accept) begin
						cnt_col_q <= c_next[ndsed_pkg::COL_W-1:0];
						cnt_row_q <= r_next[ndsed_pkg::ROW_W-1:0];
						fcnt_q    <= '0;
						state_q   <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					fcnt_q <= fcnt_q + 1'b1;
					if (fcnt_q == 3'(FETCH_LAST)) begin
						ecnt_q  <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					ecnt_q <= ecnt_q + 1'b1;
					if (ecnt_q == 3'(EVAL_CYCLES - 1)) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!emit || load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q     <= c_norm;
			row_q     <= r_norm[ndsed_pkg::ROW_W-1:0];
			drain_q   <= drain_n;
			rgb_in_q  <= {pixels.in_red, pixels.in_green, pixels.in_blue};
			geo_new_q <= {pixels.depth_index, pixels.normal_z, pixels.normal_y,
				pixels.normal_x};
		end
		if ((state_q == ST_FETCH) && (fcnt_q != '0)) begin
			win_q[2'(fcnt_q - 3'd1)] <= geo_rdata;
			if (fcnt_q == 3'd1) begin
				colour_q <= col_rdata;
			end
		end
		if (load) begin
			results.out_red    <= dk2.r;
			results.out_green  <= dk2.g;
			results.out_blue   <= dk2.b;
			results.out_column <= col_q;
			results.out_row    <= orow[ndsed_pkg::POS_W-1:0];
			results.frame_last <= ({1'b0, col_q} == w - 12'd1) && (orow == h - 12'd1);
		end
	end
endmodule

[rtl/ndsed_checker.sv]
`include "normal_depth_shade_edge_darken_unit_defines.svh"

module ndsed_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_cmd,
	input logic out_valid,
	input logic out_ready
);
	`NDSED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
	`NDSED_ASSERT_NOW(a_no_fast_out, $rose(out_valid), !$past(in_valid && in_ready), "result too early")
	`NDSED_ASSERT_NEXT(a_busy_after_pixel, in_valid && in_ready && (in_cmd == ndsed_pkg::CMD_PIXEL), !in_ready, "ready after pixel")
endmodule

bind normal_depth_shade_edge_darken_unit ndsed_checker u_ndsed_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(pixels.valid), .in_ready(pixels.ready),
	.in_cmd(pixels.cmd), .out_valid(results.valid), .out_ready(results.ready));
